FILE: hdl/tsb_pkg.sv
// package for the bilinear texture sampler
// constants, register indexes and shared types; no dependencies
package tsb_pkg;
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int FRAC_BITS  = 8;
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int AW = XW + YW;
    localparam int SW = 9;
    localparam int CW = 16;
    localparam int WW = FRAC_BITS + 1;

    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef struct packed {
        logic          mode;
        logic [SW-1:0] width;
        logic [SW-1:0] height;
    } t_cfg;

    typedef struct packed {
        logic          vld;
        logic          last;
        logic [1:0]    tap;
        logic [WW-1:0] wx;
        logic [WW-1:0] wy;
    } t_rd_ctl;
endpackage

FILE: hdl/texture_sampler_bilinear_core.sv
// bilinear texture sampler: a bilinear sample reads its four taps in turn, and the last
// tap's texel passes the memory read register and the tsb_blend registers (control: r_rd,
// r_bl); a nearest or tiny-image sample passes the memory read register and r_dtex (r_dv);
// a write gives no result; a bilinear sample makes 4 memory reads on one port, and busy
// holds off start meanwhile; result strobe o_valid lasts one cycle; receiver cannot stall
// synchronous reset restores mode 1, size 256x256; texel memory is not cleared
module texture_sampler_bilinear_core
    import tsb_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  logic          i_opcode,
    input  logic [CW-1:0] i_coord_x,
    input  logic [CW-1:0] i_coord_y,
    input  logic [7:0]    i_in_red,
    input  logic [7:0]    i_in_green,
    input  logic [7:0]    i_in_blue,
    input  logic [7:0]    i_in_alpha,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [SW-1:0] i_cfg_data,
    output logic          o_valid,
    output logic [7:0]    o_out_red,
    output logic [7:0]    o_out_green,
    output logic [7:0]    o_out_blue,
    output logic [7:0]    o_out_alpha
);
    localparam int XC = XW + FRAC_BITS;
    t_cfg r_cfg;
    logic [SW-1:0] w_eff, h_eff;
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode   <= 1'b1;
            r_cfg.width  <= SW'(MAX_WIDTH);
            r_cfg.height <= SW'(MAX_HEIGHT);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_MODE:   r_cfg.mode   <= i_cfg_data[0];
                REG_WIDTH:  r_cfg.width  <= i_cfg_data;
                REG_HEIGHT: r_cfg.height <= i_cfg_data;
                default: ;
            endcase
        end
    end
    assign w_eff = (r_cfg.width == '0) ? SW'(1) :
                   (r_cfg.width > SW'(MAX_WIDTH)) ? SW'(MAX_WIDTH) : r_cfg.width;
    assign h_eff = (r_cfg.height == '0) ? SW'(1) :
                   (r_cfg.height > SW'(MAX_HEIGHT)) ? SW'(MAX_HEIGHT) : r_cfg.height;

    // address generation for an accepted item
    logic          acc;
    logic [CW:0]   lim_x, lim_y;
    logic [CW-1:0] cx, cy;
    logic [CW:0]   rx, ry;
    logic [XW-1:0] nx, bx, r_bx;
    logic [YW-1:0] ny, by, r_by;
    logic [WW-1:0] wx, wy, r_wx, r_wy;
    logic          small_img;
    assign acc = start && !busy;
    assign lim_x = (CW+1)'(w_eff - SW'(1)) << FRAC_BITS;
    assign lim_y = (CW+1)'(h_eff - SW'(1)) << FRAC_BITS;
    assign cx = ({1'b0, i_coord_x} > lim_x) ? lim_x[CW-1:0] : i_coord_x;
    assign cy = ({1'b0, i_coord_y} > lim_y) ? lim_y[CW-1:0] : i_coord_y;
    assign rx = {1'b0, cx} + (CW+1)'(1 << (FRAC_BITS-1));
    assign ry = {1'b0, cy} + (CW+1)'(1 << (FRAC_BITS-1));
    assign nx = rx[FRAC_BITS +: XW];
    assign ny = ry[FRAC_BITS +: YW];
    assign small_img = (w_eff < SW'(2)) || (h_eff < SW'(2));
    always_comb begin
        bx = cx[FRAC_BITS +: XW];
        by = cy[FRAC_BITS +: YW];
        if (SW'(bx) + SW'(1) >= w_eff) bx = XW'(w_eff - SW'(2));
        if (SW'(by) + SW'(1) >= h_eff) by = YW'(h_eff - SW'(2));
        wx = WW'(cx[XC-1:0] - (XC'(bx) << FRAC_BITS));
        wy = WW'(cy[FRAC_BITS+YW-1:0] - ((FRAC_BITS+YW)'(by) << FRAC_BITS));
    end

    // sequencer for the remaining taps
    logic [1:0] r_tap;
    logic       r_run;
    logic       bil;
    assign bil = acc && i_opcode == OP_SAMPLE && r_cfg.mode && !small_img;
    assign busy = r_run;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_tap <= '0;
        end else if (bil) begin
            r_run <= 1'b1;
            r_tap <= 2'd1;
        end else if (r_run) begin
            r_tap <= r_tap + 2'd1;
            if (r_tap == 2'd3) r_run <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (bil) begin
            r_bx <= bx; r_by <= by; r_wx <= wx; r_wy <= wy;
        end
    end

    logic          we;
    logic [AW-1:0] addr;
    logic [31:0]   rdata;
    logic [XW:0]   wrx;
    logic [YW:0]   wry;
    assign wrx = (XW+1)'(i_coord_x >> FRAC_BITS);
    assign wry = (YW+1)'(i_coord_y >> FRAC_BITS);
    always_comb begin
        we = 1'b0;
        addr = '0;
        if (r_run) begin
            addr = {r_by + YW'(r_tap[1]), r_bx + XW'(r_tap[0])};
        end else if (acc && i_opcode == OP_WRITE) begin
            we = (i_coord_x >> FRAC_BITS) < CW'(MAX_WIDTH) &&
                 (i_coord_y >> FRAC_BITS) < CW'(MAX_HEIGHT);
            addr = {wry[YW-1:0], wrx[XW-1:0]};
        end else if (bil) begin
            addr = {by, bx};
        end else if (r_cfg.mode) begin
            addr = '0;
        end else begin
            addr = {ny, nx};
        end
    end

    tsb_texmem u_mem (
        .i_clk(i_clk), .i_we(we), .i_addr(addr),
        .i_wdata({i_in_alpha, i_in_blue, i_in_green, i_in_red}),
        .o_rdata(rdata)
    );

    // read pipeline control
    t_rd_ctl r_rd, r_bl;
    logic    r_dir;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd.vld <= 1'b0;
            r_dir    <= 1'b0;
            r_bl.vld <= 1'b0;
        end else begin
            r_rd.vld <= bil || r_run;
            r_dir    <= acc && i_opcode == OP_SAMPLE && !bil;
            r_bl.vld <= r_rd.vld && r_rd.last;
        end
        r_rd.tap  <= bil ? 2'd0 : r_tap;
        r_rd.last <= r_run && r_tap == 2'd3;
        r_rd.wx   <= bil ? wx : r_wx;
        r_rd.wy   <= bil ? wy : r_wy;
        r_bl.tap  <= '0;
        r_bl.last <= 1'b0;
        r_bl.wx   <= '0;
        r_bl.wy   <= '0;
    end

    logic [7:0] ch [0:3];
    logic [31:0] r_dtex;
    logic        r_dv;
    genvar k;
    generate
        for (k = 0; k < 4; k++) begin : g_ch
            tsb_blend u_bl (
                .i_clk(i_clk), .i_en(r_rd.vld), .i_tap(r_rd.tap),
                .i_wx(r_rd.wx), .i_wy(r_rd.wy),
                .i_texel(rdata[8*k +: 8]), .o_chan(ch[k])
            );
        end
    endgenerate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_dv <= 1'b0;
        else          r_dv <= r_dir;
        r_dtex <= rdata;
    end

    assign o_valid     = r_bl.vld || r_dv;
    assign o_out_red   = r_bl.vld ? ch[0] : r_dtex[7:0];
    assign o_out_green = r_bl.vld ? ch[1] : r_dtex[15:8];
    assign o_out_blue  = r_bl.vld ? ch[2] : r_dtex[23:16];
    assign o_out_alpha = r_bl.vld ? ch[3] : r_dtex[31:24];

    a_no_start_while_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run |-> busy) else $error("busy low during taps");
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_bl.vld && r_dv)) else $error("result collision");
    a_bil_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bil |=> ##4 r_bl.vld) else $error("missing bilinear result");
endmodule

FILE: hdl/tsb_texmem.sv
// texel memory, one port, registered synchronous read
// depends on tsb_pkg
module tsb_texmem
    import tsb_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [31:0]   i_wdata,
    output logic [31:0]   o_rdata
);
    logic [31:0] r_mem [0:(1<<AW)-1];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

FILE: hdl/tsb_blend.sv
// bilinear blend of one channel over four taps, one tap per cycle while i_en is high
// depends on tsb_pkg
module tsb_blend
    import tsb_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [1:0]    i_tap,
    input  logic [WW-1:0] i_wx,
    input  logic [WW-1:0] i_wy,
    input  logic [7:0]    i_texel,
    output logic [7:0]    o_chan
);
    localparam int PW = 8 + WW;
    localparam int AC = 8 + 2 * WW;
    localparam logic [WW-1:0] ONE = WW'(1 << FRAC_BITS);
    logic [WW-1:0] n_wa, n_wb;
    logic [PW-1:0] n_p;
    logic [AC-1:0] n_t, r_acc, n_acc;
    logic [PW-1:0] r_row;
    logic [WW-1:0] r_wb;
    always_comb begin
        n_wa = i_tap[0] ? i_wx : ONE - i_wx;
        n_wb = i_tap[1] ? i_wy : ONE - i_wy;
        n_p  = PW'(i_texel) * PW'(n_wa);
        n_t  = AC'(r_row) * AC'(r_wb);
        n_acc = (i_tap == 2'd0) ? '0 : r_acc + n_t;
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_row <= n_p;
            r_wb  <= n_wb;
            r_acc <= n_acc;
        end
    end
    // the last tap's product is folded in on the cycle after
    logic [AC-1:0] n_fin;
    assign n_fin = r_acc + n_t;
    assign o_chan = n_fin[2*FRAC_BITS +: 8];
endmodule

FILE: bench/texture_sampler_bilinear_core_tb.sv
// testbench for texture_sampler_bilinear_core: texel writes, nearest and bilinear sampling
// checked against a scoreboard with its own texel store; depends on tsb_pkg and the core
`timescale 1ns / 100ps

module testbench;
    import tsb_pkg::*;

    localparam int unsigned ONE = 1 << FRAC_BITS;

    class sampler_scoreboard;
        bit [31:0]   texels  [MAX_WIDTH*MAX_HEIGHT];
        bit          written [MAX_WIDTH*MAX_HEIGHT];
        bit          mode = 1'b1;
        int unsigned wid = 256;
        int unsigned hgt = 256;
        int unsigned tx[4], ty[4], wx, wy;
        logic [31:0] expected_texels[$];
        int          errors = 0;
        int          results = 0;

        function void set_reg(logic [1:0] idx, logic [SW-1:0] data);
            case (idx)
                REG_MODE:   mode = data[0];
                REG_WIDTH:  wid  = 32'(data);
                REG_HEIGHT: hgt  = 32'(data);
                default: ;
            endcase
        endfunction

        function int unsigned eff(int unsigned r, int unsigned maxv);
            if (r < 1) return 1;
            if (r > maxv) return maxv;
            return r;
        endfunction

        function int unsigned eff_w();
            return eff(wid, MAX_WIDTH);
        endfunction

        function int unsigned eff_h();
            return eff(hgt, MAX_HEIGHT);
        endfunction

        // texel addresses and weights touched by one sample
        function int plan_taps(int unsigned cx, int unsigned cy);
            int unsigned w, h, x0, y0;
            w = eff_w();
            h = eff_h();
            if (cx > ((w - 1) << FRAC_BITS)) cx = (w - 1) << FRAC_BITS;
            if (cy > ((h - 1) << FRAC_BITS)) cy = (h - 1) << FRAC_BITS;
            if (!mode) begin
                tx[0] = (cx + ONE / 2) >> FRAC_BITS;
                ty[0] = (cy + ONE / 2) >> FRAC_BITS;
                return 1;
            end
            if (w < 2 || h < 2) begin
                tx[0] = 0;
                ty[0] = 0;
                return 1;
            end
            x0 = cx >> FRAC_BITS;
            if (x0 + 1 >= w) x0 = w - 2;
            y0 = cy >> FRAC_BITS;
            if (y0 + 1 >= h) y0 = h - 2;
            wx = cx - (x0 << FRAC_BITS);
            wy = cy - (y0 << FRAC_BITS);
            tx = '{x0, x0 + 1, x0, x0 + 1};
            ty = '{y0, y0, y0 + 1, y0 + 1};
            return 4;
        endfunction

        function bit readable(int unsigned cx, int unsigned cy);
            int n;
            n = plan_taps(cx, cy);
            for (int i = 0; i < n; i++)
                if (!written[ty[i] * MAX_WIDTH + tx[i]]) return 0;
            return 1;
        endfunction

        function void note_input(logic op, logic [CW-1:0] cx, logic [CW-1:0] cy,
                                 logic [31:0] texel);
            int          n;
            int unsigned a, r0, r1, v, t[4];
            logic [31:0] res;
            if (op == OP_WRITE) begin
                a = (cy >> FRAC_BITS) * MAX_WIDTH + (cx >> FRAC_BITS);
                texels[a]  = texel;
                written[a] = 1'b1;
                return;
            end
            n = plan_taps(cx, cy);
            if (n == 1) begin
                expected_texels.push_back(texels[ty[0] * MAX_WIDTH + tx[0]]);
                return;
            end
            for (int k = 0; k < 4; k++) begin
                for (int i = 0; i < 4; i++)
                    t[i] = (texels[ty[i] * MAX_WIDTH + tx[i]] >> (8 * k)) & 8'hFF;
                r0 = t[0] * (ONE - wx) + t[1] * wx;
                r1 = t[2] * (ONE - wx) + t[3] * wx;
                v  = r0 * (ONE - wy) + r1 * wy;
                res[8*k +: 8] = 8'(v >> (2 * FRAC_BITS));
            end
            expected_texels.push_back(res);
        endfunction

        function void check_result(logic [31:0] got);
            logic [31:0] want;
            results++;
            if (expected_texels.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = expected_texels.pop_front();
            for (int k = 0; k < 4; k++)
                if (got[8*k +: 8] !== want[8*k +: 8]) begin
                    $display("%0t: channel %0d expected %h actual %h", $time, k,
                             want[8*k +: 8], got[8*k +: 8]);
                    errors++;
                end
        endfunction
    endclass

    logic          i_clk = 1'b0;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    logic          i_opcode;
    logic [CW-1:0] i_coord_x, i_coord_y;
    logic [7:0]    i_in_red, i_in_green, i_in_blue, i_in_alpha;
    logic          i_cfg_valid;
    logic          o_cfg_ready;
    logic [1:0]    i_cfg_index;
    logic [SW-1:0] i_cfg_data;
    logic          o_valid;
    logic [7:0]    o_out_red, o_out_green, o_out_blue, o_out_alpha;

    sampler_scoreboard sb = new();
    int burst_left = 0;
    bit no_gaps = 0;
    int n_samples = 0, n_writes = 0;

    texture_sampler_bilinear_core uut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk)
        if (i_rst_n === 1'b1 && o_valid === 1'b1)
            sb.check_result({o_out_alpha, o_out_blue, o_out_green, o_out_red});

    task automatic send_item(logic op, logic [CW-1:0] cx, logic [CW-1:0] cy,
                             logic [31:0] texel);
        start      <= 1'b1;
        i_opcode   <= op;
        i_coord_x  <= cx;
        i_coord_y  <= cy;
        {i_in_alpha, i_in_blue, i_in_green, i_in_red} <= texel;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_input(op, cx, cy, texel);
        if (op == OP_WRITE) n_writes++;
        else n_samples++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 20);
            if (!no_gaps && $urandom_range(0, 2) != 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    endtask

    // hold off until every expected result has come and the core has settled
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_texels.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [SW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        sb.set_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_texel(int unsigned x, int unsigned y);
        send_item(OP_WRITE, {x[7:0], 8'($urandom)}, {y[7:0], 8'($urandom)}, $urandom);
    endtask

    function automatic logic [CW-1:0] pick_coord(int unsigned s);
        case ($urandom_range(0, 9))
            0: return CW'($urandom);
            1: return CW'((s - 1) << FRAC_BITS);
            2: return {8'($urandom_range(0, s - 1)), 8'h80};
            3: return CW'($urandom_range(((s > 3) ? s - 3 : 0) << FRAC_BITS, 16'hFFFF));
            default: return CW'($urandom_range(0, (s << FRAC_BITS) - 1));
        endcase
    endfunction

    task automatic sample_random();
        logic [CW-1:0] cx, cy;
        int tries;
        tries = 0;
        do begin
            cx = pick_coord(sb.eff_w());
            cy = pick_coord(sb.eff_h());
            tries++;
        end while (!sb.readable(cx, cy) && tries < 8);
        if (!sb.readable(cx, cy)) begin
            cx = CW'($urandom_range(0, 2 << FRAC_BITS));
            cy = CW'($urandom_range(0, 2 << FRAC_BITS));
        end
        send_item(OP_SAMPLE, cx, cy, $urandom);
    endtask

    // writes every texel of a small image, or the two corner blocks of a large one
    task automatic fill_image();
        int unsigned w, h;
        w = sb.eff_w();
        h = sb.eff_h();
        if (w * h <= 160) begin
            for (int unsigned y = 0; y < h; y++)
                for (int unsigned x = 0; x < w; x++) write_texel(x, y);
        end else begin
            for (int unsigned y = 0; y < 4; y++)
                for (int unsigned x = 0; x < 4; x++) begin
                    write_texel(x, y);
                    write_texel((w > 4) ? w - 4 + x : x, (h > 4) ? h - 4 + y : y);
                end
        end
    endtask

    typedef struct {
        logic          mode;
        logic [SW-1:0] w;
        logic [SW-1:0] h;
    } t_phase_cfg;

    t_phase_cfg phases[12] = '{
        '{1'b1, 9'd256, 9'd256}, '{1'b0, 9'd256, 9'd256}, '{1'b1, 9'd4, 9'd4},
        '{1'b0, 9'd5, 9'd3}, '{1'b1, 9'd1, 9'd7}, '{1'b1, 9'd6, 9'd1},
        '{1'b0, 9'd1, 9'd1}, '{1'b1, 9'd0, 9'd511}, '{1'b1, 9'd2, 9'd2},
        '{1'b0, 9'd511, 9'd0}, '{1'b1, 9'd17, 9'd9}, '{1'b0, 9'd3, 9'd200}
    };

    initial begin
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_opcode    <= OP_WRITE;
        i_coord_x   <= '0;
        i_coord_y   <= '0;
        i_in_red    <= '0;
        i_in_green  <= '0;
        i_in_blue   <= '0;
        i_in_alpha  <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= REG_MODE;
        i_cfg_data  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extreme colours, corners, half points, clamping
        send_item(OP_WRITE, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
        send_item(OP_WRITE, 16'h01FF, 16'h00FF, 32'h0000_0000);
        send_item(OP_WRITE, 16'h0000, 16'h0100, 32'h00FF_00FF);
        send_item(OP_WRITE, 16'h0180, 16'h0180, 32'hFF00_FF00);
        send_item(OP_WRITE, 16'hFEFF, 16'hFEFF, 32'h8040_2010);
        send_item(OP_WRITE, 16'hFF00, 16'hFE00, 32'hFFFF_FFFF);
        send_item(OP_WRITE, 16'hFE00, 16'hFF00, 32'h0102_0408);
        send_item(OP_WRITE, 16'hFFFF, 16'hFFFF, 32'h7F80_FF01);
        send_item(OP_SAMPLE, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
        send_item(OP_SAMPLE, 16'h0080, 16'h0080, 32'h0);
        send_item(OP_SAMPLE, 16'h00FF, 16'h0001, 32'h0);
        send_item(OP_SAMPLE, 16'h0100, 16'h00FF, 32'h0);
        send_item(OP_SAMPLE, 16'hFFFF, 16'hFFFF, 32'h0);
        send_item(OP_SAMPLE, 16'hFF00, 16'hFF00, 32'h0);
        send_item(OP_SAMPLE, 16'hFE80, 16'hFEC0, 32'h0);
        drain();

        foreach (phases[p]) begin
            write_reg(REG_MODE, {8'($urandom), phases[p].mode});
            write_reg(REG_WIDTH, phases[p].w);
            write_reg(REG_HEIGHT, phases[p].h);
            no_gaps = (p % 3 == 2);
            fill_image();
            for (int i = 0; i < 32; i++) begin
                if (i == 16) drain();
                if ($urandom_range(0, 4) == 0) begin
                    if ($urandom_range(0, 3) == 0)
                        send_item(OP_WRITE, CW'($urandom), CW'($urandom), $urandom);
                    else
                        write_texel($urandom_range(0, sb.eff_w() - 1),
                                    $urandom_range(0, sb.eff_h() - 1));
                end else begin
                    sample_random();
                end
            end
            drain();
        end

        $display("covered %0d samples and %0d texel writes over %0d settings",
                 n_samples, n_writes, $size(phases));
        $display("%0d results checked, %0d mismatches", sb.results, sb.errors);
        if (sb.errors == 0 && sb.expected_texels.size() == 0)
            $display("[texture_sampler_bilinear_core] OK");
        else
            $display("[texture_sampler_bilinear_core] ERROR");
        $finish;
    end

    initial begin
        #3ms;
        $display("[texture_sampler_bilinear_core] ERROR");
        $finish;
    end
endmodule
